// ===== rtl/auv_pkg.sv =====
`timescale 1ns / 1ps
package auv_pkg;

  localparam int RATE_W    = 18;
  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 16;
  localparam int QDEPTH    = 2;

  localparam logic [1:0] CFG_FROM_RATE = 2'd0;
  localparam logic [1:0] CFG_TO_RATE   = 2'd1;
  localparam logic [1:0] CFG_MODE      = 2'd2;

  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_ZERO   = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;
  localparam logic [1:0] MODE_CUBIC  = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       run_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       last;
    logic                       run_end_out;
    logic                       burst_cut;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     pass;
  } cmd_t;

  typedef struct packed {
    logic [RATE_W-1:0] from_rate;
    logic [RATE_W-1:0] to_rate;
    logic [1:0]        mode;
    logic              clear;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] rem_init;
    logic [RATE_W-1:0] num_init;
    logic [RATE_W-1:0] divisor;
    logic [4:0]        steps;
  } div_req_t;

endpackage

// ===== rtl/audio_upsampling_interpolator_unit.sv =====
`timescale 1ns / 1ps
// Fractional-rate audio upsampler: each input transfer carries one 16-bit sample and yields up
// to MAX_RATIO output transfers by hold, zero stuffing, linear or Catmull-Rom cubic
// interpolation, with equal rates passing the sample straight through. Inputs enter a two-entry
// queue, so the input side keeps taking transfers while the output register waits, until the
// queue is full. Per output, the bit-serial fraction divider runs, then linear and cubic modes
// take their steps on the shared multiplier, then the sample is emitted; a cut burst adds a
// division for the position remainder. The divider and the single multiplier set the item rate.
module audio_upsampling_interpolator_unit import auv_pkg::*; #(
  parameter int MAX_RATIO = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [RATE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  cfg_t                 cfg;
  logic                 push;
  cmd_t                 push_cmd;
  logic                 q_full;
  logic                 pop;
  logic                 q_valid;
  cmd_t                 q_cmd;
  div_req_t             div_req;
  logic                 div_done;
  logic [FRAC_BITS-1:0] div_quot;
  logic [RATE_W-1:0]    div_rem;

  auv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full),
    .cfg       (cfg)
  );

  auv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  auv_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  auv_back #(
    .MAX_RATIO (MAX_RATIO)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .div_req   (div_req),
    .div_done  (div_done),
    .div_quot  (div_quot),
    .div_rem   (div_rem),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/auv_front.sv =====
`timescale 1ns / 1ps
module auv_front import auv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [RATE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              push,
  output cmd_t              push_cmd,
  input  logic              q_full,
  output cfg_t              cfg
);

  logic [RATE_W-1:0] from_rate_r;
  logic [RATE_W-1:0] to_rate_r;
  logic [1:0]        mode_r;
  logic [RATE_W-1:0] fr;
  logic [RATE_W-1:0] tr;
  logic              known;

  assign cfg_ready = 1'b1;
  assign known = (cfg_index == CFG_FROM_RATE) || (cfg_index == CFG_TO_RATE) ||
                 (cfg_index == CFG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_rate_r <= RATE_W'(1);
      to_rate_r   <= RATE_W'(1);
      mode_r      <= MODE_CUBIC;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FROM_RATE: from_rate_r <= cfg_data;
        CFG_TO_RATE:   to_rate_r   <= cfg_data;
        CFG_MODE:      mode_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // A rate of zero behaves as a rate of one.
  assign fr = (from_rate_r == '0) ? RATE_W'(1) : from_rate_r;
  assign tr = (to_rate_r == '0) ? RATE_W'(1) : to_rate_r;

  assign cfg.from_rate = fr;
  assign cfg.to_rate   = tr;
  assign cfg.mode      = mode_r;
  assign cfg.clear     = cfg_valid && known;

  assign in_ready      = !q_full;
  assign push          = in_valid && !q_full;
  assign push_cmd.item = in_data;
  assign push_cmd.pass = (fr == tr);

endmodule

// ===== rtl/auv_queue.sv =====
`timescale 1ns / 1ps
module auv_queue import auv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t       mem_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = (count_r == 2'(QDEPTH));
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/auv_divider.sv =====
`timescale 1ns / 1ps
module auv_divider import auv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quot,
  output logic [RATE_W-1:0]    rem
);

  logic                 busy_r;
  logic                 done_r;
  logic [4:0]           cnt_r;
  logic [RATE_W-1:0]    rem_r;
  logic [RATE_W-1:0]    num_r;
  logic [RATE_W-1:0]    div_r;
  logic [FRAC_BITS-1:0] q_r;
  logic [RATE_W:0]      r2;
  logic                 ge;

  // One restoring step per cycle; the partial remainder stays below the divisor.
  assign r2 = {rem_r, num_r[RATE_W-1]};
  assign ge = (r2 >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd1);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == 5'd1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      num_r <= req.num_init;
      div_r <= req.divisor;
      cnt_r <= req.steps;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? RATE_W'(r2 - {1'b0, div_r}) : r2[RATE_W-1:0];
      num_r <= {num_r[RATE_W-2:0], 1'b0};
      q_r   <= {q_r[FRAC_BITS-2:0], ge};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/auv_back.sv =====
`timescale 1ns / 1ps
module auv_back import auv_pkg::*; #(
  parameter int MAX_RATIO = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 pop,
  output div_req_t             div_req,
  input  logic                 div_done,
  input  logic [FRAC_BITS-1:0] div_quot,
  input  logic [RATE_W-1:0]    div_rem,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int MW   = $clog2(MAX_RATIO + 1);
  localparam int CUTW = RATE_W + MW + 1;
  localparam int TW   = 40;
  localparam int WW   = 60;
  localparam int OPW  = 22;
  localparam int SPLIT = 19;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PASS  = 8'b0000_0010,
    S_START = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_CALC  = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_MOD   = 8'b1000_0000
  } state_t;

  state_t                     state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] c_r;
  logic                       re_r;
  logic [RATE_W:0]            at_r, at_nxt;
  logic [RATE_W-1:0]          pos_r, pos_nxt;
  logic signed [SAMPLE_W-1:0] h_r [3];
  logic                       shift_hist;
  logic                       cut_r, cut_nxt;
  logic [MW-1:0]              made_r, made_nxt;
  logic [FRAC_BITS-1:0]       f_r;
  logic [2:0]                 st_r, st_nxt;
  logic signed [TW-1:0]       prod_r, acc_r, t_r;
  logic signed [TW-1:0]       t_nxt;
  logic signed [SAMPLE_W-1:0] v_r, v_nxt;
  logic                       out_valid_r;
  out_item_t                  out_r;
  logic                       out_load;
  out_item_t                  out_nxt;
  logic                       out_free;

  logic signed [OPW-1:0]      p0x, p1x, p2x, p3x, a_c, b_c, dp_c, d_c;
  logic signed [OPW-1:0]      mul_a;
  logic signed [FRAC_BITS:0]  mul_b;
  logic signed [OPW+FRAC_BITS:0] mul_p;
  logic signed [WW-1:0]       wide, wide_sh;
  logic signed [TW-1:0]       frac;
  logic [CUTW-1:0]            cut_sum;
  logic                       last_c;

  function automatic logic signed [SAMPLE_W-1:0] round_clamp(
      input logic signed [TW-1:0] n, input logic s17);
    logic        neg;
    logic [TW:0] m;
    logic [TW:0] q;
    neg = n[TW-1];
    m = neg ? ((TW+1)'(0) - (TW+1)'(n)) : (TW+1)'(n);
    q = s17 ? ((m + (TW+1)'(65536)) >> 17) : ((m + (TW+1)'(32768)) >> 16);
    if (!neg) begin
      round_clamp = (q >= (TW+1)'(32767)) ? 16'sh7fff : $signed(q[SAMPLE_W-1:0]);
    end else begin
      round_clamp = (q >= (TW+1)'(32768)) ? 16'sh8000 :
                    $signed(16'(~q[SAMPLE_W-1:0] + 16'd1));
    end
  endfunction

  assign p0x  = OPW'(h_r[0]);
  assign p1x  = OPW'(h_r[1]);
  assign p2x  = OPW'(h_r[2]);
  assign p3x  = OPW'(c_r);
  assign a_c  = (p0x <<< 1) - (p1x <<< 2) - p1x + (p2x <<< 2) - p3x;
  assign d_c  = p1x - p2x;
  assign b_c  = d_c + (d_c <<< 1) + p3x - p0x;
  assign dp_c = p2x - p0x;

  always_comb begin
    case (st_r)
      3'd2, 3'd5: mul_a = OPW'({3'b000, t_r[SPLIT-1:0]});
      3'd3, 3'd6: mul_a = OPW'($signed(t_r[TW-1:SPLIT]));
      default:    mul_a = (cfg.mode == MODE_LINEAR) ? (p3x - p2x) : b_c;
    endcase
  end
  assign mul_b = $signed({1'b0, f_r});
  assign mul_p = mul_a * mul_b;

  // The product t*f is rebuilt from its two halves, then floored by 2^16.
  assign wide    = (WW'(prod_r) <<< SPLIT) + WW'(acc_r);
  assign wide_sh = wide >>> FRAC_BITS;
  assign frac    = wide_sh[TW-1:0];

  assign cut_sum  = CUTW'(at_r) + CUTW'(cfg.from_rate) * CUTW'(MAX_RATIO);
  assign last_c   = (made_r == MW'(MAX_RATIO - 1)) ||
                    ((RATE_W+2)'(at_r) + (RATE_W+2)'(cfg.from_rate) >=
                     (RATE_W+2)'(cfg.to_rate));
  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt  = state_r;
    at_nxt     = at_r;
    pos_nxt    = pos_r;
    cut_nxt    = cut_r;
    made_nxt   = made_r;
    st_nxt     = st_r;
    t_nxt      = t_r;
    v_nxt      = v_r;
    shift_hist = 1'b0;
    out_load   = 1'b0;
    out_nxt    = out_r;
    div_req    = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          at_nxt    = {1'b0, pos_r};
          state_nxt = q_cmd.pass ? S_PASS : S_START;
        end
      end
      S_PASS: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.out_sample  = c_r;
          out_nxt.last        = 1'b1;
          out_nxt.run_end_out = re_r;
          out_nxt.burst_cut   = 1'b0;
          state_nxt           = S_IDLE;
        end
      end
      S_START: begin
        made_nxt = '0;
        cut_nxt  = (cut_sum < CUTW'(cfg.to_rate));
        if (at_r >= (RATE_W+1)'(cfg.to_rate)) begin
          pos_nxt    = RATE_W'(at_r - (RATE_W+1)'(cfg.to_rate));
          shift_hist = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = at_r[RATE_W-1:0];
          div_req.divisor  = cfg.to_rate;
          div_req.steps    = 5'(FRAC_BITS);
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_nxt    = '0;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        st_nxt = st_r + 3'd1;
        case (cfg.mode)
          MODE_HOLD: begin
            v_nxt     = c_r;
            state_nxt = S_EMIT;
          end
          MODE_ZERO: begin
            v_nxt     = (made_r == '0) ? c_r : '0;
            state_nxt = S_EMIT;
          end
          MODE_LINEAR: begin
            if (st_r == 3'd1) begin
              v_nxt     = round_clamp((TW'(p2x) <<< FRAC_BITS) + prod_r, 1'b0);
              state_nxt = S_EMIT;
            end
          end
          default: begin
            case (st_r)
              3'd1: t_nxt = (TW'(a_c) <<< FRAC_BITS) + prod_r;
              3'd4: t_nxt = (TW'(dp_c) <<< FRAC_BITS) + frac;
              3'd7: begin
                v_nxt     = round_clamp((TW'(p1x) <<< (FRAC_BITS + 1)) + frac, 1'b1);
                state_nxt = S_EMIT;
              end
              default: ;
            endcase
          end
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.out_sample  = v_r;
          out_nxt.last        = last_c;
          out_nxt.run_end_out = last_c && re_r;
          out_nxt.burst_cut   = cut_r;
          made_nxt            = made_r + MW'(1);
          at_nxt              = at_r + (RATE_W+1)'(cfg.from_rate);
          if (last_c) begin
            state_nxt = S_FIN;
          end else begin
            div_req.start    = 1'b1;
            div_req.rem_init = at_nxt[RATE_W-1:0];
            div_req.divisor  = cfg.to_rate;
            div_req.steps    = 5'(FRAC_BITS);
            state_nxt        = S_DIV;
          end
        end
      end
      S_FIN: begin
        if (cut_r) begin
          div_req.start    = 1'b1;
          div_req.num_init = RATE_W'((RATE_W+1)'(cfg.to_rate) - at_r);
          div_req.divisor  = cfg.from_rate;
          div_req.steps    = 5'(RATE_W);
          state_nxt        = S_MOD;
        end else begin
          pos_nxt    = RATE_W'(at_r - (RATE_W+1)'(cfg.to_rate));
          shift_hist = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_MOD: begin
        if (div_done) begin
          pos_nxt    = (div_rem == '0) ? '0 : cfg.from_rate - div_rem;
          shift_hist = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      h_r[0]      <= '0;
      h_r[1]      <= '0;
      h_r[2]      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg.clear) begin
        pos_r  <= '0;
        h_r[0] <= '0;
        h_r[1] <= '0;
        h_r[2] <= '0;
      end else begin
        pos_r <= pos_nxt;
        if (shift_hist) begin
          h_r[0] <= h_r[1];
          h_r[1] <= h_r[2];
          h_r[2] <= c_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      c_r  <= q_cmd.item.in_sample;
      re_r <= q_cmd.item.run_end;
    end
    if ((state_r == S_DIV) && div_done) begin
      f_r <= div_quot;
    end
    if (state_r == S_CALC) begin
      prod_r <= TW'(mul_p);
      if ((st_r == 3'd3) || (st_r == 3'd6)) begin
        acc_r <= prod_r;
      end
    end
    at_r   <= at_nxt;
    cut_r  <= cut_nxt;
    made_r <= made_nxt;
    st_r   <= st_nxt;
    t_r    <= t_nxt;
    v_r    <= v_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
